FILE: rtl/qla_pkg.sv
// Shared types, constants and a helper function for the Q-learning agent.
// Used by every module of the block except the generic RAM.
`default_nettype none

package qla_pkg;

    localparam int NUM_STATES  = 32768;
    localparam int NUM_ACTIONS = 9;
    localparam int Q_WIDTH     = 24;
    localparam int FRAC_BITS   = 16;

    localparam int STATE_W  = 15;
    localparam int STATE_AW = $clog2(NUM_STATES);
    localparam int ACT_W    = 4;
    localparam int CNT_W    = $clog2(NUM_ACTIONS + 1);
    localparam int Q_DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int QADDR_W  = $clog2(Q_DEPTH);
    localparam int COEF_W   = 17;
    localparam int COEF_FRAC = 16;
    localparam int EDRAW_W  = 16;
    localparam int PDRAW_W  = 8;
    localparam int KIND_W   = 3;

    localparam int P1_W = COEF_W + 1 + Q_WIDTH;
    localparam int T1_W = P1_W - COEF_FRAC;
    localparam int TD_W = Q_WIDTH + 3;
    localparam int P2_W = COEF_W + 1 + TD_W;
    localparam int T2_W = P2_W - COEF_FRAC;
    localparam int NQ_W = Q_WIDTH + 6;

    localparam logic [COEF_W-1:0] COEF_ONE       = COEF_W'(65536);
    localparam logic [COEF_W-1:0] LEARN_RESET    = COEF_W'(6554);
    localparam logic [COEF_W-1:0] DISCOUNT_RESET = COEF_W'(58982);
    localparam logic [COEF_W-1:0] EXPLORE_RESET  = COEF_W'(6554);

    localparam logic [1:0] REG_LEARN    = 2'd0;
    localparam logic [1:0] REG_DISCOUNT = 2'd1;
    localparam logic [1:0] REG_EXPLORE  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_GREEDY  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXPLORE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NO_USE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UPDATE  = 3'd5;

    localparam logic signed [Q_WIDTH-1:0] Q_MINUS_ONE =
        -Q_WIDTH'(signed'(1 << FRAC_BITS));
    localparam logic signed [NQ_W-1:0] QMAX = NQ_W'((1 << (Q_WIDTH - 1)) - 1);
    localparam logic signed [NQ_W-1:0] QMIN = -NQ_W'(1 << (Q_WIDTH - 1));

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRES_S,
        ST_CAPS,
        ST_OLDQ,
        ST_SCAN,
        ST_MUL1,
        ST_TD,
        ST_MUL2,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clr_wr;
        logic pres_nst;
        logic cap_pres_s;
        logic cap_pres_n;
        logic q_old_rd;
        logic scan;
        logic mul1;
        logic td;
        logic mul2;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic req_upd;
        logic act_bad;
        logic scan_end;
        logic clr_last;
    } sts_t;

    // The index-th set bit of the mask, where index = (draw * count) >> 8.
    function automatic logic [ACT_W-1:0] random_pick(input logic [NUM_ACTIONS-1:0] mask,
                                                     input logic [PDRAW_W-1:0] draw);
        logic [CNT_W-1:0]         cnt;
        logic [CNT_W+PDRAW_W-1:0] prod;
        logic [CNT_W-1:0]         idx;
        logic [CNT_W-1:0]         seen;
        logic [ACT_W-1:0]         pick;
        logic                     found;
        cnt = '0;
        for (int i = 0; i < NUM_ACTIONS; i++)
        begin
            cnt = cnt + CNT_W'(mask[i]);
        end
        prod  = (CNT_W+PDRAW_W)'(draw) * (CNT_W+PDRAW_W)'(cnt);
        idx   = prod[CNT_W+PDRAW_W-1:PDRAW_W];
        seen  = '0;
        pick  = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_ACTIONS; i++)
        begin
            if (mask[i] && !found)
            begin
                if (seen == idx)
                begin
                    pick  = ACT_W'(i);
                    found = 1'b1;
                end
                seen = seen + 1'b1;
            end
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qla_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module qla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/qla_ctrl.sv
// Controller state machine of the Q-learning agent: sequences clearing,
// table scans and the update arithmetic. Depends on qla_pkg.
`default_nettype none

module qla_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire qla_pkg::sts_t sts,
    output qla_pkg::cmd_t      cmd
);
    import qla_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_PRES_S;
            ST_PRES_S: state_next = ST_CAPS;
            ST_CAPS:   state_next = sts.req_upd ? ST_OLDQ : ST_SCAN;
            ST_OLDQ:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = (sts.req_upd && !sts.act_bad) ? ST_MUL1 : ST_DONE;
                end
            end
            ST_MUL1:   state_next = ST_TD;
            ST_TD:     state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR:  cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_PRES_S: ;
            ST_CAPS:
            begin
                cmd.cap_pres_s = 1'b1;
                cmd.pres_nst   = 1'b1;
            end
            ST_OLDQ:
            begin
                cmd.cap_pres_n = 1'b1;
                cmd.q_old_rd   = 1'b1;
            end
            ST_SCAN:   cmd.scan = 1'b1;
            ST_MUL1:   cmd.mul1 = 1'b1;
            ST_TD:     cmd.td = 1'b1;
            ST_MUL2:   cmd.mul2 = 1'b1;
            ST_WRITE:  cmd.commit = 1'b1;
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/qla_dp.sv
// Datapath of the Q-learning agent: request and coefficient registers, the
// Q table and present-bit memories, scan logic, update arithmetic and the
// result register. Depends on qla_pkg and qla_ram.
`default_nettype none

module qla_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire qla_pkg::cmd_t                    cmd,
    output qla_pkg::sts_t                         sts,
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_addr,
    input  wire logic [qla_pkg::COEF_W-1:0]       cfg_wdata,
    input  wire logic                             req_type,
    input  wire logic [qla_pkg::STATE_W-1:0]      state_index,
    input  wire logic [qla_pkg::NUM_ACTIONS-1:0]  move_mask,
    input  wire logic [qla_pkg::ACT_W-1:0]        action_taken,
    input  wire logic signed [qla_pkg::Q_WIDTH-1:0] reward_value,
    input  wire logic [qla_pkg::STATE_W-1:0]      next_state_index,
    input  wire logic [qla_pkg::EDRAW_W-1:0]      explore_draw,
    input  wire logic [qla_pkg::PDRAW_W-1:0]      pick_draw,
    output logic [qla_pkg::ACT_W-1:0]             chosen_move,
    output logic [qla_pkg::KIND_W-1:0]            choice_kind,
    output logic signed [qla_pkg::Q_WIDTH-1:0]    new_q_value,
    output logic                                  saturated_flag
);
    import qla_pkg::*;

    // Coefficients
    logic [COEF_W-1:0] learn_reg, discount_reg, explore_reg, cfg_val;

    assign cfg_val = (cfg_wdata > COEF_ONE) ? COEF_ONE : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_reg    <= LEARN_RESET;
            discount_reg <= DISCOUNT_RESET;
            explore_reg  <= EXPLORE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LEARN:    learn_reg    <= cfg_val;
                REG_DISCOUNT: discount_reg <= cfg_val;
                REG_EXPLORE:  explore_reg  <= cfg_val;
                default: ;
            endcase
        end
    end

    // Request registers
    logic                      upd_reg;
    logic [STATE_AW-1:0]       st_reg, nst_reg;
    logic [NUM_ACTIONS-1:0]    mask_reg;
    logic [ACT_W-1:0]          act_reg;
    logic                      act_bad_reg;
    logic signed [Q_WIDTH-1:0] reward_reg;
    logic [EDRAW_W-1:0]        edraw_reg;
    logic [PDRAW_W-1:0]        pdraw_reg;
    logic [QADDR_W-1:0]        base_s_reg, base_n_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            upd_reg     <= req_type;
            st_reg      <= state_index[STATE_AW-1:0];
            nst_reg     <= next_state_index[STATE_AW-1:0];
            mask_reg    <= move_mask;
            act_reg     <= action_taken;
            act_bad_reg <= (action_taken >= ACT_W'(NUM_ACTIONS));
            reward_reg  <= reward_value;
            edraw_reg   <= explore_draw;
            pdraw_reg   <= pick_draw;
            base_s_reg  <= QADDR_W'(state_index[STATE_AW-1:0]) * QADDR_W'(NUM_ACTIONS);
            base_n_reg  <= QADDR_W'(next_state_index[STATE_AW-1:0]) * QADDR_W'(NUM_ACTIONS);
        end
    end

    // Clearing sweep over the present bits after reset
    logic [STATE_AW-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Memories
    logic [NUM_ACTIONS-1:0] pres_rdata, pres_wdata;
    logic [STATE_AW-1:0]    pres_waddr, pres_raddr;
    logic                   pres_we;
    logic [Q_WIDTH-1:0]     q_rdata;
    logic [QADDR_W-1:0]     q_raddr, q_waddr;
    logic [Q_WIDTH-1:0]     q_wdata;
    logic [NUM_ACTIONS-1:0] pres_s_reg, pres_n_reg;

    assign pres_we    = cmd.clr_wr || cmd.commit;
    assign pres_waddr = cmd.clr_wr ? clr_reg : st_reg;
    assign pres_wdata = cmd.clr_wr ? '0 : (pres_s_reg | (NUM_ACTIONS'(1) << act_reg));
    assign pres_raddr = cmd.pres_nst ? nst_reg : st_reg;

    qla_ram #(.WIDTH(NUM_ACTIONS), .DEPTH(NUM_STATES)) u_pres_ram (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .raddr (pres_raddr),
        .rdata (pres_rdata)
    );

    // Scan over the moves of one state
    logic [CNT_W-1:0]          cnt_reg;
    logic [ACT_W-1:0]          m_idx;
    logic [ACT_W-1:0]          act_eff;
    logic [NUM_ACTIONS-1:0]    use_bits;
    logic signed [Q_WIDTH-1:0] best_reg, old_reg, q_val;
    logic [ACT_W-1:0]          best_idx_reg;
    logic                      best_ok_reg;

    assign act_eff  = act_bad_reg ? '0 : act_reg;
    assign q_raddr  = cmd.q_old_rd ? (base_s_reg + QADDR_W'(act_eff))
                                   : ((upd_reg ? base_n_reg : base_s_reg) + QADDR_W'(cnt_reg));
    assign m_idx    = cnt_reg[ACT_W-1:0] - 1'b1;
    assign use_bits = mask_reg & (upd_reg ? pres_n_reg : pres_s_reg);
    assign q_val    = signed'(q_rdata);

    qla_ram #(.WIDTH(Q_WIDTH), .DEPTH(Q_DEPTH)) u_q_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cnt_reg     <= '0;
            best_reg    <= req_type ? '0 : Q_MINUS_ONE;
            best_ok_reg <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (cmd.scan)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == '0)
            begin
                old_reg <= pres_s_reg[act_eff] ? q_val : '0;
            end
            else if (use_bits[m_idx] && (q_val > best_reg))
            begin
                best_reg     <= q_val;
                best_idx_reg <= m_idx;
                best_ok_reg  <= 1'b1;
            end
        end
        if (cmd.cap_pres_s)
        begin
            pres_s_reg <= pres_rdata;
        end
        if (cmd.cap_pres_n)
        begin
            pres_n_reg <= pres_rdata;
        end
    end

    // Update arithmetic: gamma product, TD error, alpha product, saturation
    logic signed [P1_W-1:0]    prod1_reg, sum1;
    logic signed [T1_W-1:0]    term1;
    logic signed [TD_W-1:0]    td_reg;
    logic signed [P2_W-1:0]    prod2_reg, sum2;
    logic signed [T2_W-1:0]    term2;
    logic signed [NQ_W-1:0]    nq_wide;
    logic signed [Q_WIDTH-1:0] nq_sat;
    logic                      nq_clip;
    logic signed [Q_WIDTH-1:0] nq_reg;
    logic                      sat_reg;

    assign sum1  = prod1_reg + P1_W'(1 << (COEF_FRAC - 1));
    assign term1 = sum1[P1_W-1:COEF_FRAC];
    assign sum2  = prod2_reg + P2_W'(1 << (COEF_FRAC - 1));
    assign term2 = sum2[P2_W-1:COEF_FRAC];
    assign nq_wide = NQ_W'(old_reg) + NQ_W'(term2);

    always_comb
    begin
        nq_clip = 1'b1;
        if (nq_wide > QMAX)
        begin
            nq_sat = QMAX[Q_WIDTH-1:0];
        end
        else if (nq_wide < QMIN)
        begin
            nq_sat = QMIN[Q_WIDTH-1:0];
        end
        else
        begin
            nq_sat  = nq_wide[Q_WIDTH-1:0];
            nq_clip = 1'b0;
        end
    end

    assign q_waddr = base_s_reg + QADDR_W'(act_eff);
    assign q_wdata = nq_sat;

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            prod1_reg <= P1_W'(signed'({1'b0, discount_reg})) * P1_W'(best_reg);
        end
        if (cmd.td)
        begin
            td_reg <= TD_W'(reward_reg) + TD_W'(term1) - TD_W'(old_reg);
        end
        if (cmd.mul2)
        begin
            prod2_reg <= P2_W'(signed'({1'b0, learn_reg})) * P2_W'(td_reg);
        end
        if (cmd.load_in)
        begin
            nq_reg  <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            nq_reg  <= nq_sat;
            sat_reg <= nq_clip;
        end
    end

    // Result register
    logic [ACT_W-1:0]  pick;
    logic [ACT_W-1:0]  move_sel;
    logic [KIND_W-1:0] kind_sel;

    assign pick = random_pick(mask_reg, pdraw_reg);

    always_comb
    begin
        move_sel = pick;
        if (upd_reg)
        begin
            kind_sel = KIND_UPDATE;
            move_sel = '0;
        end
        else if (mask_reg == '0)
        begin
            kind_sel = KIND_EMPTY;
            move_sel = '0;
        end
        else if ({1'b0, edraw_reg} < explore_reg)
        begin
            kind_sel = KIND_EXPLORE;
        end
        else if (pres_s_reg == '0)
        begin
            kind_sel = KIND_UNKNOWN;
        end
        else if (best_ok_reg)
        begin
            kind_sel = KIND_GREEDY;
            move_sel = best_idx_reg;
        end
        else
        begin
            kind_sel = KIND_NO_USE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            chosen_move    <= move_sel;
            choice_kind    <= kind_sel;
            new_q_value    <= nq_reg;
            saturated_flag <= sat_reg;
        end
    end

    assign sts.req_upd  = upd_reg;
    assign sts.act_bad  = act_bad_reg;
    assign sts.scan_end = (cnt_reg == CNT_W'(NUM_ACTIONS));
    assign sts.clr_last = (clr_reg == STATE_AW'(NUM_STATES - 1));

endmodule

`default_nettype wire

FILE: rtl/tabular_q_learning_agent.sv
// Top level of the tabular Q-learning agent: stream ports and field packing.
// Depends on qla_pkg, qla_ctrl, qla_dp and qla_ram.
//
// After reset the block sweeps the present-bit memory, one state per cycle,
// over all 32768 states, and takes no request until the sweep is done. A
// request is accepted only in the idle state, so the block finishes one request
// and loads its result before it accepts the next. A request reads the present
// bits and then the nine Q entries of a state one after another through the
// single read port of the Q table, followed for an update by two registered
// multiplies and the write-back. The result register lets the next request
// start while a result waits to be taken.
`default_nettype none

module tabular_q_learning_agent (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_addr,
    input  wire logic [qla_pkg::COEF_W-1:0]   cfg_wdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // state_index[14:0], move_mask[23:15], action_taken[27:24], reward_value[51:28],
    // next_state_index[66:52], explore_draw[82:67], pick_draw[90:83], zero fill
    input  wire logic [95:0]                  s_tdata,
    // req_type[0]
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // chosen_move[3:0], new_q_value[27:4], saturated_flag[28], zero fill
    output logic [31:0]                       m_tdata,
    // choice_kind[2:0]
    output logic [qla_pkg::KIND_W-1:0]        m_tuser
);
    import qla_pkg::*;

    cmd_t                      cmd;
    sts_t                      sts;
    logic [ACT_W-1:0]          chosen_move;
    logic signed [Q_WIDTH-1:0] new_q_value;
    logic                      saturated_flag;

    qla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qla_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .req_type         (s_tuser),
        .state_index      (s_tdata[14:0]),
        .move_mask        (s_tdata[23:15]),
        .action_taken     (s_tdata[27:24]),
        .reward_value     (signed'(s_tdata[51:28])),
        .next_state_index (s_tdata[66:52]),
        .explore_draw     (s_tdata[82:67]),
        .pick_draw        (s_tdata[90:83]),
        .chosen_move      (chosen_move),
        .choice_kind      (m_tuser),
        .new_q_value      (new_q_value),
        .saturated_flag   (saturated_flag)
    );

    assign m_tdata = {3'b000, saturated_flag, new_q_value, chosen_move};

endmodule

`default_nettype wire

FILE: test/tabular_q_learning_agent_tb.sv
// Self-checking testbench for the tabular Q-learning agent.
// Predicts every result with an internal table model and compares it field by field.
// Depends on qla_pkg and the tabular_q_learning_agent RTL.
`default_nettype none

module tabular_q_learning_agent_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qla_pkg::*;

    typedef struct packed {
        logic [3:0]  move;
        logic [2:0]  kind;
        logic [23:0] qval;
        logic        sat;
    } agent_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [16:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    tabular_q_learning_agent u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state: only entries that have been written are kept.
    int unsigned   alpha_coef;
    int unsigned   gamma_coef;
    int unsigned   eps_coef;
    logic [23:0]   q_table [int];
    logic [8:0]    seen_moves [int];
    agent_result_t pending_results [$];

    int unsigned error_count;
    int unsigned result_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_cycles;
    int unsigned kind_hits [6];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [8:0] stored_bits(input int s);
        return seen_moves.exists(s) ? seen_moves[s] : 9'd0;
    endfunction

    function automatic logic signed [63:0] round_q16(input logic signed [63:0] v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [3:0] pick_move(input logic [8:0] mask, input logic [7:0] draw);
        int cnt;
        int idx;
        cnt = $countones(mask);
        idx = (int'(draw) * cnt) >> 8;
        for (int m = 0; m < NUM_ACTIONS; m++)
        begin
            if (mask[m])
            begin
                if (idx == 0)
                    return 4'(m);
                idx--;
            end
        end
        return 4'd0;
    endfunction

    function automatic agent_result_t predict_agent(input logic is_update,
                                                    input logic [95:0] d);
        agent_result_t r;
        int st;
        int nst;
        logic [8:0] mask;
        logic [3:0] act;
        logic [8:0] pres;
        logic signed [63:0] best_q;
        logic signed [63:0] reward;
        logic signed [63:0] old_q;
        logic signed [63:0] max_next;
        logic signed [63:0] td;
        logic signed [63:0] nq;
        int best;
        r = '0;
        st = int'(d[14:0]);
        mask = d[23:15];
        act = d[27:24];
        nst = int'(d[66:52]);
        if (!is_update)
        begin
            pres = stored_bits(st);
            if (mask == 0)
                r.kind = KIND_EMPTY;
            else if (int'(d[82:67]) < int'(eps_coef))
            begin
                r.kind = KIND_EXPLORE;
                r.move = pick_move(mask, d[90:83]);
            end
            else if (pres == 0)
            begin
                r.kind = KIND_UNKNOWN;
                r.move = pick_move(mask, d[90:83]);
            end
            else
            begin
                best_q = -64'sd65536;
                best = -1;
                for (int m = 0; m < NUM_ACTIONS; m++)
                begin
                    if (mask[m] && pres[m]
                        && $signed(q_table[st * 9 + m]) > best_q)
                    begin
                        best_q = $signed(q_table[st * 9 + m]);
                        best = m;
                    end
                end
                if (best < 0)
                begin
                    r.kind = KIND_NO_USE;
                    r.move = pick_move(mask, d[90:83]);
                end
                else
                begin
                    r.kind = KIND_GREEDY;
                    r.move = 4'(best);
                end
            end
            return r;
        end
        r.kind = KIND_UPDATE;
        if (act >= NUM_ACTIONS)
            return r;
        reward = $signed(d[51:28]);
        pres = stored_bits(st);
        old_q = pres[act] ? $signed(q_table[st * 9 + act]) : 64'sd0;
        max_next = 0;
        pres = stored_bits(nst);
        for (int m = 0; m < NUM_ACTIONS; m++)
        begin
            if (mask[m] && pres[m] && $signed(q_table[nst * 9 + m]) > max_next)
                max_next = $signed(q_table[nst * 9 + m]);
        end
        td = reward + round_q16($signed({32'd0, gamma_coef}) * max_next) - old_q;
        nq = old_q + round_q16($signed({32'd0, alpha_coef}) * td);
        if (nq > 64'sd8388607)
        begin
            nq = 64'sd8388607;
            r.sat = 1'b1;
        end
        if (nq < -64'sd8388608)
        begin
            nq = -64'sd8388608;
            r.sat = 1'b1;
        end
        q_table[st * 9 + act] = nq[23:0];
        seen_moves[st] = stored_bits(st) | (9'd1 << act);
        r.qval = nq[23:0];
        return r;
    endfunction

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin
        agent_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[3:0] != want.move)
                    report_mismatch("chosen_move", m_tdata[3:0], want.move);
                if (m_tuser != want.kind)
                    report_mismatch("choice_kind", m_tuser, want.kind);
                else if (want.kind <= KIND_UPDATE)
                    kind_hits[want.kind]++;
                if (m_tdata[27:4] != want.qval)
                    report_mismatch("new_q_value", $signed(m_tdata[27:4]),
                                    $signed(want.qval));
                if (m_tdata[28] != want.sat)
                    report_mismatch("saturated_flag", m_tdata[28], want.sat);
                if (m_tdata[31:29] != 3'd0)
                    report_mismatch("tdata fill", m_tdata[31:29], 0);
            end
        end
        if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The request stays offered after acceptance until the next request or a
    // pause replaces it, so each time step sees one drive of s_tvalid.
    task automatic send_request(input logic is_update, input logic [95:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_update;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_agent(is_update, d));
    endtask

    function automatic logic [95:0] pack_request(input int st, input logic [8:0] mask,
                                                 input logic [3:0] act,
                                                 input logic [23:0] reward,
                                                 input int nst, input logic [15:0] ed,
                                                 input logic [7:0] pd);
        return {5'd0, pd, ed, 15'(nst), reward, act, mask, 15'(st)};
    endfunction

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_coef(input logic [1:0] idx, input logic [16:0] value);
        int unsigned v;
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        v = (value > 17'd65536) ? 65536 : int'(value);
        case (idx)
            REG_LEARN:    alpha_coef = v;
            REG_DISCOUNT: gamma_coef = v;
            default:      eps_coef   = v;
        endcase
    endtask

    // Small state pool so that choose requests hit trained boards often.
    function automatic int pool_state();
        return ($urandom_range(3) == 0) ? int'($urandom_range(32767))
                                        : int'($urandom_range(12)) * 2521;
    endfunction

    function automatic logic [23:0] random_reward();
        case ($urandom_range(4))
            0:       return 24'h7FFFFF - 24'($urandom_range(3));
            1:       return 24'h800000 + 24'($urandom_range(3));
            2:       return 24'($urandom);
            default: return 24'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    task automatic random_request();
        logic is_update;
        is_update = $urandom_range(1);
        send_request(is_update,
                     pack_request(pool_state(),
                                  ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom),
                                  ($urandom_range(7) == 0) ? 4'($urandom_range(9, 15))
                                                           : 4'($urandom_range(8)),
                                  random_reward(), pool_state(), 16'($urandom),
                                  8'($urandom)));
    endtask

    task automatic test_directed();
        // Unknown state, empty mask, exploring with both draw extremes.
        send_request(0, pack_request(0, 9'h1FF, 0, 0, 0, 16'hFFFF, 8'hFF));
        send_request(0, pack_request(32767, 9'h000, 0, 0, 0, 16'hFFFF, 8'h00));
        send_request(0, pack_request(5, 9'h155, 0, 0, 0, 16'h0000, 8'h00));
        send_request(0, pack_request(5, 9'h1FF, 0, 0, 0, 16'h0000, 8'hFF));
        // Updates: full positive, full negative, out-of-range action.
        send_request(1, pack_request(1, 9'h1FF, 0, 24'h7FFFFF, 2, 0, 0));
        send_request(1, pack_request(1, 9'h1FF, 8, 24'h800000, 2, 0, 0));
        send_request(1, pack_request(1, 9'h1FF, 15, 24'h7FFFFF, 2, 0, 0));
        send_request(1, pack_request(1, 9'h1FF, 9, 24'h123456, 2, 0, 0));
        send_request(0, pack_request(1, 9'h1FF, 0, 0, 0, 16'hFFFF, 8'h80));
        // Only entry below -1: no usable entry.
        send_request(0, pack_request(1, 9'h100, 0, 0, 0, 16'hFFFF, 8'h80));
        // Mask excluding all present moves.
        send_request(0, pack_request(1, 9'h0FE, 0, 0, 0, 16'hFFFF, 8'h40));
        // Bootstrapped update from a trained next state.
        send_request(1, pack_request(3, 9'h001, 4, 24'h010000, 1, 0, 0));
        send_request(1, pack_request(3, 9'h000, 4, 24'h010000, 1, 0, 0));
        send_request(0, pack_request(3, 9'h010, 0, 0, 0, 16'hFFFF, 8'h00));
    endtask

    task automatic test_config_corners();
        drain_results();
        write_coef(REG_LEARN, 17'd65536);
        write_coef(REG_DISCOUNT, 17'd65536);
        write_coef(REG_EXPLORE, 17'd0);
        repeat (40) random_request();
        drain_results();
        write_coef(REG_LEARN, 17'h1FFFF);
        write_coef(REG_DISCOUNT, 17'd0);
        write_coef(REG_EXPLORE, 17'h1FFFF);
        repeat (30) random_request();
        drain_results();
        write_coef(REG_LEARN, 17'd0);
        write_coef(REG_DISCOUNT, 17'd32768);
        write_coef(REG_EXPLORE, 17'd65535);
        repeat (30) random_request();
        drain_results();
        write_coef(REG_LEARN, 17'd40000);
        write_coef(REG_DISCOUNT, 17'd58982);
        write_coef(REG_EXPLORE, 17'd6554);
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (120) random_request();
        send_idle_pct = 81;
        repeat (90) random_request();
        send_idle_pct = 0;
        recv_stall_pct = 81;
        repeat (90) random_request();
        send_idle_pct = 11;
        recv_stall_pct = 11;
        repeat (100) random_request();
    endtask

    task automatic test_backpressure();
        recv_stall_pct = 0;
        send_idle_pct = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        hold_cycles <= 300;
        repeat (12) random_request();
        // Sender pauses until every result has been taken.
        drain_results();
        repeat (10) random_request();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        alpha_coef = 6554;
        gamma_coef = 58982;
        eps_coef = 6554;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_corners();
        test_idle_phases();
        test_backpressure();
        drain_results();
        $display("Checked %0d results over %0d kinds of outcome, four idling phases,",
                 result_count, 6);
        $display("kinds greedy/explore/unknown/no-use/empty/update: %0d %0d %0d %0d %0d %0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
                 kind_hits[5]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: tabular_q_learning_agent.f
rtl/qla_pkg.sv
rtl/qla_ram.sv
rtl/qla_ctrl.sv
rtl/qla_dp.sv
rtl/tabular_q_learning_agent.sv
test/tabular_q_learning_agent_tb.sv
